/* hdl/bls_pkg.sv */
`default_nettype none

package bls_pkg;

    // list geometry
    localparam int CAPACITY  = 16;
    localparam int WORD_BITS = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // port field widths
    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic take;        // request accepted this cycle, latch key
        logic push_front;
        logic push_back;
        logic pop;         // read front word, advance front
        logic pop_done;    // capture popped word as result
        logic scan_start;  // read front word, arm scan
        logic scan_step;   // read next word of scan
        logic res_found;   // capture scanned word as result
        logic res_ok;      // result ok, zero value
        logic res_none;    // result not found or empty
        logic res_full;    // result full, push refused
        logic load_out;    // move result into output register
    } bls_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;         // read word equals key
        logic scan_last;   // word under compare is the last one
        logic out_free;    // output register can take a result
    } bls_sts_t;

    // port word to stored word, truncate or zero extend
    function automatic word_t to_word(input logic [VALUE_W-1:0] v);
        logic [WORD_BITS+VALUE_W-1:0] wide;
        wide = {{WORD_BITS{1'b0}}, v};
        return wide[WORD_BITS-1:0];
    endfunction

    // stored word to port value, low bits
    function automatic logic [VALUE_W-1:0] to_value(input word_t w);
        logic [WORD_BITS+VALUE_W-1:0] wide;
        wide = {{VALUE_W{1'b0}}, w};
        return wide[VALUE_W-1:0];
    endfunction

    // count to port field, low bits
    function automatic logic [COUNT_W-1:0] to_count(input cnt_t c);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        return wide[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/bls_ctrl.sv */
`default_nettype none

module bls_ctrl
    import bls_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [REQ_W-1:0] s_req_type,
    input  wire bls_sts_t         sts,
    output bls_cmd_t              cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP_RD = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_POST   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    state_next = S_POST;
                    unique case (s_req_type)
                        REQ_PUSH_FRONT: begin
                            if (sts.full) begin
                                cmd.res_full = 1'b1;
                            end else begin
                                cmd.push_front = 1'b1;
                                cmd.res_ok     = 1'b1;
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (sts.full) begin
                                cmd.res_full = 1'b1;
                            end else begin
                                cmd.push_back = 1'b1;
                                cmd.res_ok    = 1'b1;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (sts.empty) begin
                                cmd.res_none = 1'b1;
                            end else begin
                                cmd.pop    = 1'b1;
                                state_next = S_POP_RD;
                            end
                        end
                        REQ_SEARCH: begin
                            if (sts.empty) begin
                                cmd.res_none = 1'b1;
                            end else begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                        end
                        default: begin
                            cmd.res_none = 1'b1;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                cmd.pop_done = 1'b1;
                state_next   = S_POST;
            end
            S_SCAN: begin
                if (sts.hit) begin
                    cmd.res_found = 1'b1;
                    state_next    = S_POST;
                end else if (sts.scan_last) begin
                    cmd.res_none = 1'b1;
                    state_next   = S_POST;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_POST: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/bls_datapath.sv */
`default_nettype none

module bls_datapath
    import bls_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bls_cmd_t            cmd,
    output bls_sts_t                 sts,
    input  wire logic [VALUE_W-1:0]  s_item_value,
    input  wire logic [VALUE_W-1:0]  s_search_key,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [VALUE_W-1:0]       m_out_value,
    output logic [STATUS_W-1:0]      m_status,
    output logic [COUNT_W-1:0]       m_item_count,
    output logic                     m_is_empty
);

    localparam idx_t LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam cnt_t FULL_CNT = CNT_W'(CAPACITY);

    // word store
    word_t mem [CAPACITY];
    word_t rd_data_reg;

    idx_t  front_reg;
    idx_t  front_next;
    cnt_t  count_reg;
    cnt_t  count_next;
    idx_t  scan_addr_reg;
    idx_t  scan_addr_next;
    cnt_t  scan_left_reg;
    cnt_t  scan_left_next;
    word_t key_reg;

    word_t                res_value_reg;
    logic [STATUS_W-1:0]  res_status_reg;

    logic                 m_valid_reg;
    logic [VALUE_W-1:0]   m_out_value_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [COUNT_W-1:0]   m_item_count_reg;
    logic                 m_is_empty_reg;

    idx_t              front_dec;
    idx_t              front_inc;
    idx_t              scan_inc;
    logic [CNT_W:0]    back_sum;
    idx_t              back_addr;
    idx_t              wr_addr;
    logic              wr_en;
    idx_t              rd_addr;

    // ring arithmetic
    always_comb begin
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - idx_t'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + idx_t'(1);
        scan_inc  = (scan_addr_reg == LAST_IDX) ? '0 : scan_addr_reg + idx_t'(1);
        back_sum  = {{(CNT_W + 1 - IDX_W){1'b0}}, front_reg} + {1'b0, count_reg};
        if (back_sum >= (CNT_W + 1)'(CAPACITY)) begin
            back_sum = back_sum - (CNT_W + 1)'(CAPACITY);
        end
        back_addr = back_sum[IDX_W-1:0];
    end

    // write and read port selection
    assign wr_en   = cmd.push_front | cmd.push_back;
    assign wr_addr = cmd.push_front ? front_dec : back_addr;
    assign rd_addr = cmd.scan_step ? scan_addr_reg : front_reg;

    // memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= to_word(s_item_value);
        end
        rd_data_reg <= mem[rd_addr];
    end

    // front pointer, count and scan bookkeeping
    always_comb begin
        front_next     = front_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        if (cmd.push_front) begin
            front_next = front_dec;
            count_next = count_reg + cnt_t'(1);
        end
        if (cmd.push_back) begin
            count_next = count_reg + cnt_t'(1);
        end
        if (cmd.pop) begin
            front_next = front_inc;
            count_next = count_reg - cnt_t'(1);
        end
        if (cmd.scan_start) begin
            scan_addr_next = front_inc;
            scan_left_next = count_reg;
        end
        if (cmd.scan_step) begin
            scan_addr_next = scan_inc;
            scan_left_next = scan_left_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_addr_reg <= scan_addr_next;
        scan_left_reg <= scan_left_next;
        if (cmd.take) begin
            key_reg <= to_word(s_search_key);
        end
    end

    // pending result
    always_ff @(posedge aclk) begin
        if (cmd.res_ok) begin
            res_value_reg  <= '0;
            res_status_reg <= STAT_OK;
        end
        if (cmd.res_none) begin
            res_value_reg  <= '0;
            res_status_reg <= STAT_NONE;
        end
        if (cmd.res_full) begin
            res_value_reg  <= '0;
            res_status_reg <= STAT_FULL;
        end
        if (cmd.pop_done || cmd.res_found) begin
            res_value_reg  <= rd_data_reg;
            res_status_reg <= STAT_OK;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_out_value_reg  <= to_value(res_value_reg);
            m_status_reg     <= res_status_reg;
            m_item_count_reg <= to_count(count_reg);
            m_is_empty_reg   <= (count_reg == '0);
        end
    end

    // status to controller
    always_comb begin
        sts.full      = (count_reg == FULL_CNT);
        sts.empty     = (count_reg == '0);
        sts.hit       = (rd_data_reg == key_reg);
        sts.scan_last = (scan_left_reg == cnt_t'(1));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_value  = m_out_value_reg;
    assign m_status     = m_status_reg;
    assign m_item_count = m_item_count_reg;
    assign m_is_empty   = m_is_empty_reg;

endmodule

`default_nettype wire

/* hdl/bounded_list_with_search_top.sv */
// channel  | valid / ready        | payload
// ---------+----------------------+-------------------------------------------
// request  | s_valid / s_ready    | s_req_type, s_item_value, s_search_key
// result   | m_valid / m_ready    | m_out_value, m_status, m_item_count,
//          |                      | m_is_empty
//
// one request at a time; the scan reads one ring entry per cycle, from the
// front word on, and stops at the first hit or after the last stored word.
// synchronous active-low reset empties the list; stored words keep no reset.
// a result waiting in the output register does not block the next request;
// the following result is held until the output register is taken.
`default_nettype none

module bounded_list_with_search_top
    import bls_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [REQ_W-1:0]    s_req_type,
    input  wire logic [VALUE_W-1:0]  s_item_value,
    input  wire logic [VALUE_W-1:0]  s_search_key,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [VALUE_W-1:0]       m_out_value,
    output logic [STATUS_W-1:0]      m_status,
    output logic [COUNT_W-1:0]       m_item_count,
    output logic                     m_is_empty
);

    bls_cmd_t cmd;
    bls_sts_t sts;

    // controller
    bls_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    bls_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_item_value (s_item_value),
        .s_search_key (s_search_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_status     (m_status),
        .m_item_count (m_item_count),
        .m_is_empty   (m_is_empty)
    );

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bls_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;

    // one result as seen on the m_ side
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                empty;
    } list_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type;
    logic [VALUE_W-1:0]   s_item_value;
    logic [VALUE_W-1:0]   s_search_key;
    logic                 m_valid;
    logic                 m_ready;
    logic [VALUE_W-1:0]   m_out_value;
    logic [STATUS_W-1:0]  m_status;
    logic [COUNT_W-1:0]   m_item_count;
    logic                 m_is_empty;

    // list contents as the block should hold them
    word_t model_ring [CAPACITY];
    int    model_front;
    int    model_count;

    list_result_t pending_results [$];
    int           mismatch_count;
    int           cycle_count;
    int           burst_left;

    bounded_list_with_search_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_item_value (s_item_value),
        .s_search_key (s_search_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_status     (m_status),
        .m_item_count (m_item_count),
        .m_is_empty   (m_is_empty)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // apply one request to the list copy, return what the block must report
    function automatic list_result_t apply_list_request(input logic [REQ_W-1:0] kind,
                                                        input logic [VALUE_W-1:0] item,
                                                        input logic [VALUE_W-1:0] key);
        list_result_t r;
        word_t        w;
        r.value  = '0;
        r.status = STAT_OK;
        case (kind)
            REQ_PUSH_FRONT: begin
                if (model_count >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    model_front = (model_front + CAPACITY - 1) % CAPACITY;
                    model_ring[model_front] = item;
                    model_count++;
                end
            end
            REQ_PUSH_BACK: begin
                if (model_count >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else begin
                    model_ring[(model_front + model_count) % CAPACITY] = item;
                    model_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (model_count == 0) begin
                    r.status = STAT_NONE;
                end else begin
                    r.value = model_ring[model_front];
                    model_front = (model_front + 1) % CAPACITY;
                    model_count--;
                end
            end
            default: begin
                // first equal word from the front wins
                r.status = STAT_NONE;
                for (int i = 0; i < model_count; i++) begin
                    w = model_ring[(model_front + i) % CAPACITY];
                    if (w == key && r.status == STAT_NONE) begin
                        r.value  = w;
                        r.status = STAT_OK;
                    end
                end
            end
        endcase
        r.count = COUNT_W'(model_count);
        r.empty = (model_count == 0);
        return r;
    endfunction

    // data words: extremes, small values for duplicates, full random
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // search key: mostly a word that is in the list
    function automatic logic [VALUE_W-1:0] pick_key();
        if (model_count > 0 && $urandom_range(9) < 6)
            return model_ring[(model_front + $urandom_range(model_count - 1)) % CAPACITY];
        return pick_word();
    endfunction

    // drive one request, wait for it to be taken, then maybe leave a gap
    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [VALUE_W-1:0] item,
                                input logic [VALUE_W-1:0] key);
        int gap;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_item_value <= item;
        s_search_key <= key;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(apply_list_request(kind, item, key));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // hold off new requests until every result is back
    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 4) @(posedge aclk);
    endtask

    // pop and search on an empty list
    task automatic test_empty_list();
        send_request(REQ_POP_FRONT, '1, '0);
        send_request(REQ_SEARCH, '0, '0);
        send_request(REQ_SEARCH, '1, '1);
    endtask

    // all-zero and all-one words through both pushes, search hit and miss, a pop
    task automatic test_extreme_words();
        send_request(REQ_PUSH_BACK, '0, '1);
        send_request(REQ_PUSH_FRONT, '1, '0);
        send_request(REQ_SEARCH, '0, '1);
        send_request(REQ_SEARCH, '1, '0);
        send_request(REQ_SEARCH, '0, 32'h0000_0001);
        send_request(REQ_POP_FRONT, '0, '0);
    endtask

    // fill to capacity from both ends, refused pushes, search of the last word
    task automatic test_full_list();
        logic [VALUE_W-1:0] last_word;
        for (int i = 0; model_count < CAPACITY; i++)
            send_request((i % 2) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                         32'hA5A5_0000 + i, $urandom);
        send_request(REQ_PUSH_FRONT, 32'h1234_5678, $urandom);
        send_request(REQ_PUSH_BACK, 32'h8765_4321, $urandom);
        last_word = model_ring[(model_front + model_count - 1) % CAPACITY];
        send_request(REQ_SEARCH, $urandom, last_word);
    endtask

    // random traffic in phases that lean toward filling, draining or mixing
    task automatic test_random_traffic();
        int push_pct;
        int phase_left;
        int roll;
        logic [REQ_W-1:0] kind;
        phase_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) pause_until_drained();
            if (phase_left == 0) begin
                phase_left = $urandom_range(40, 120);
                case ($urandom_range(3))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    2:       push_pct = 50;
                    default: push_pct = 35;
                endcase
            end
            phase_left--;
            roll = $urandom_range(99);
            if (roll < push_pct)
                kind = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            else if (roll < push_pct + (100 - push_pct) / 2)
                kind = REQ_POP_FRONT;
            else
                kind = REQ_SEARCH;
            send_request(kind, pick_word(), pick_key());
        end
    endtask

    // result receiver with changing stall patterns
    initial begin
        int mode;
        int tick;
        m_ready = 1'b0;
        tick    = 0;
        wait (aresetn === 1'b1);
        forever begin
            mode = $urandom_range(3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge aclk);
                tick++;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(1) == 1);
                    2:       m_ready <= ($urandom_range(7) == 0);
                    default: m_ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    // compare each result with the oldest prediction
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: value %h status %0d count %0d empty %0b",
                             m_out_value, m_status, m_item_count, m_is_empty);
            end else begin
                want = pending_results.pop_front();
                if (m_out_value !== want.value || m_status !== want.status ||
                    m_item_count !== want.count || m_is_empty !== want.empty) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("result mismatch: exp value %h status %0d count %0d empty %0b",
                                 want.value, want.status, want.count, want.empty);
                        $display("                 got value %h status %0d count %0d empty %0b",
                                 m_out_value, m_status, m_item_count, m_is_empty);
                    end
                end
            end
        end
    end

    // reset, tests in turn, drain, verdict
    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_PUSH_FRONT;
        s_item_value   = '0;
        s_search_key   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 8;
        model_front    = 0;
        model_count    = 0;
        for (int i = 0; i < CAPACITY; i++) model_ring[i] = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        pause_until_drained();
        test_extreme_words();
        test_full_list();
        pause_until_drained();
        test_random_traffic();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (CAPACITY + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/bls_pkg.sv
hdl/bls_ctrl.sv
hdl/bls_datapath.sv
hdl/bounded_list_with_search_top.sv
dv/tb_top.sv
